// File: design/bbmf_pkg.sv
// Shared types and constants for the box blur mean filter.
// No dependencies; bbmf_lane and box_blur_mean_filter_top import this package.
package bbmf_pkg;

  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 256;
  localparam int MAX_RADIUS_DEF = 50;

  localparam int NUM_LANES = 4;
  localparam int SUM_W     = 24;
  localparam int ROW_W     = 16;
  localparam int DIVD_W    = 32;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [1:0] CFG_RADIUS = 2'd0;
  localparam logic [1:0] CFG_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_HEIGHT = 2'd2;

  localparam logic [5:0] RADIUS_RST = 6'd3;
  localparam logic [8:0] WIDTH_RST  = 9'd256;
  localparam logic [8:0] HEIGHT_RST = 9'd256;

  typedef struct packed {
    logic       operation;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [7:0] query_x;
    logic [7:0] query_y;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
  } out_word_t;

  typedef struct packed {
    logic [1:0] index;
    logic [8:0] data;
  } cfg_word_t;

  // Per-lane control issued by the sequencer.
  typedef struct packed {
    logic pix_take;
    logic row_clr;
    logic wr_en;
    logic above_vld;
    logic rd_en;
    logic acc_clr;
    logic acc_en;
    logic acc_sub;
    logic acc_zero;
    logic div_start;
    logic div_step;
  } lane_ctrl_t;

endpackage

// File: design/bbmf_chan_if.sv
// Valid/ready channel carrying one word of type T.
// Used for the input, result and configuration channels.
interface bbmf_chan_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// File: design/bbmf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bbmf_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// File: design/bbmf_lane.sv
// One color lane: summed-area table, row sum, corner accumulator, divider.
// Depends on bbmf_pkg and bbmf_ram.
module bbmf_lane #(
  parameter int AW = 16,
  parameter int PW = 18
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  bbmf_pkg::lane_ctrl_t ctrl,
  input  logic [7:0]           pix,
  input  logic [AW-1:0]        rd_addr,
  input  logic [AW-1:0]        wr_addr,
  input  logic [PW-1:0]        area,
  output logic [7:0]           mean
);
  import bbmf_pkg::*;

  logic [ROW_W-1:0]  row_sum_r;
  logic [SUM_W-1:0]  rdata;
  logic [SUM_W-1:0]  wdata;
  logic [DIVD_W-1:0] acc_r;
  logic [DIVD_W-1:0] term;
  logic [DIVD_W-1:0] quo_r;
  logic [PW-1:0]     rem_r;
  logic [PW:0]       rem_sh;
  logic              ge;

  bbmf_ram #(.WIDTH(SUM_W), .DEPTH(2 ** AW)) u_ram (
    .clk  (clk),
    .we   (ctrl.wr_en),
    .waddr(wr_addr),
    .wdata(wdata),
    .re   (ctrl.rd_en),
    .raddr(rd_addr),
    .rdata(rdata)
  );

  assign wdata  = SUM_W'(row_sum_r) + (ctrl.above_vld ? rdata : '0);
  assign term   = ctrl.acc_zero ? '0 : DIVD_W'(rdata);
  assign rem_sh = {rem_r, quo_r[DIVD_W-1]};
  assign ge     = rem_sh >= {1'b0, area};
  assign mean   = quo_r[7:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_sum_r <= '0;
    end else if (ctrl.pix_take) begin
      row_sum_r <= (ctrl.row_clr ? '0 : row_sum_r) + ROW_W'(pix);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.acc_clr) begin
      acc_r <= '0;
    end else if (ctrl.acc_en) begin
      acc_r <= ctrl.acc_sub ? acc_r - term : acc_r + term;
    end
    // restoring divide, one quotient bit per cycle
    if (ctrl.div_start) begin
      quo_r <= acc_r;
      rem_r <= '0;
    end else if (ctrl.div_step) begin
      quo_r <= {quo_r[DIVD_W-2:0], ge};
      rem_r <= ge ? PW'(rem_sh - {1'b0, area}) : rem_sh[PW-1:0];
    end
  end
endmodule

// File: design/box_blur_mean_filter_top.sv
// Box blur mean filter: four color lanes over summed-area tables in RAM.
// Load: accept, read the sum above, write the new sum, one pixel at a time.
// Query: bounds, multiply, four corner reads on each lane's read port and a
//   32-step restoring divide lead to the result register, then the next accept.
// Reset (rst_n, synchronous): load position (0,0), radius 3, frame 256x256;
//   tables undefined until loaded. Uses bbmf_pkg, bbmf_chan_if, bbmf_lane.
module box_blur_mean_filter_top #(
  parameter int MAX_WIDTH  = bbmf_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bbmf_pkg::MAX_HEIGHT_DEF,
  parameter int MAX_RADIUS = bbmf_pkg::MAX_RADIUS_DEF
) (
  input logic          clk,
  input logic          rst_n,
  bbmf_chan_if.sink    in_ch,
  bbmf_chan_if.source  out_ch,
  bbmf_chan_if.sink    cfg_ch
);
  import bbmf_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int XW0   = $clog2((MAX_WIDTH > MAX_HEIGHT ? MAX_WIDTH : MAX_HEIGHT) + 1);
  localparam int XW    = XW0 > 9 ? XW0 : 9;
  localparam int PW    = 2 * XW;

  typedef enum logic [3:0] {
    S_IDLE, S_LD_RD, S_LD_WR, S_Q_BND, S_Q_MUL, S_Q_RD, S_Q_LAST, S_Q_DS, S_Q_DIV,
    S_Q_OUT
  } state_t;

  state_t         state_r;
  logic [5:0]     radius_r;
  logic [8:0]     width_r, height_r;
  logic [XW-1:0]  w_eff, h_eff;
  logic [XW-1:0]  ld_x_r, ld_y_r, lx, ly;
  logic [AW-1:0]  ld_addr_r, ld_rb_r, laddr, lrb, cur_addr_r;
  logic           cur_y0_r, restart;
  logic [XW-1:0]  qx_r, qy_r, x1_r, x2_r, y1_r, y2_r, x1, x2, y1, y2;
  logic [XW:0]    x2w, y2w;
  logic [5:0]     r_eff;
  logic [PW-1:0]  area_r;
  logic [AW-1:0]  yb1_r, yb2_r, corner_addr, rd_addr;
  logic           x1z_r, y1z_r, corner_zero;
  logic [4:0]     cnt_r;
  logic           tag_vld_r, tag_sub_r, tag_zero_r;
  logic           out_vld_r;
  out_word_t      out_r;
  lane_ctrl_t     ctrl;
  logic [7:0]     pix [NUM_LANES];
  logic [7:0]     mean [NUM_LANES];
  logic           in_fire, cfg_fire;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign cfg_fire = cfg_ch.valid && cfg_ch.ready;
  assign in_ch.ready  = state_r == S_IDLE;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_vld_r;
  assign out_ch.data  = out_r;

  assign pix[0] = in_ch.data.red;
  assign pix[1] = in_ch.data.green;
  assign pix[2] = in_ch.data.blue;
  assign pix[3] = in_ch.data.alpha;

  // saturate the frame geometry and radius
  always_comb begin
    if (width_r == '0) w_eff = XW'(1);
    else if (XW'(width_r) > XW'(MAX_WIDTH)) w_eff = XW'(MAX_WIDTH);
    else w_eff = XW'(width_r);
    if (height_r == '0) h_eff = XW'(1);
    else if (XW'(height_r) > XW'(MAX_HEIGHT)) h_eff = XW'(MAX_HEIGHT);
    else h_eff = XW'(height_r);
    r_eff = ({2'b0, radius_r} > 8'(MAX_RADIUS)) ? 6'(MAX_RADIUS) : radius_r;
  end

  // current load position, restarted when it lies outside the frame
  assign restart = (ld_x_r >= w_eff) || (ld_y_r >= h_eff);
  assign lx      = restart ? '0 : ld_x_r;
  assign ly      = restart ? '0 : ld_y_r;
  assign laddr   = restart ? '0 : ld_addr_r;
  assign lrb     = restart ? '0 : ld_rb_r;

  // window bounds, shifted by one so that 0 stands for -1
  assign x1  = (qx_r > XW'(r_eff)) ? qx_r - XW'(r_eff) : '0;
  assign y1  = (qy_r > XW'(r_eff)) ? qy_r - XW'(r_eff) : '0;
  assign x2w = (XW+1)'(qx_r) + (XW+1)'(r_eff) + (XW+1)'(1);
  assign y2w = (XW+1)'(qy_r) + (XW+1)'(r_eff) + (XW+1)'(1);
  assign x2  = (x2w > (XW+1)'(w_eff)) ? w_eff : x2w[XW-1:0];
  assign y2  = (y2w > (XW+1)'(h_eff)) ? h_eff : y2w[XW-1:0];

  always_comb begin
    case (cnt_r[1:0])
      2'd0: begin
        corner_addr = yb2_r + AW'(x2_r) - AW'(1);
        corner_zero = 1'b0;
      end
      2'd1: begin
        corner_addr = yb2_r + AW'(x1_r) - AW'(1);
        corner_zero = x1z_r;
      end
      2'd2: begin
        corner_addr = yb1_r + AW'(x2_r) - AW'(1);
        corner_zero = y1z_r;
      end
      default: begin
        corner_addr = yb1_r + AW'(x1_r) - AW'(1);
        corner_zero = x1z_r || y1z_r;
      end
    endcase
    rd_addr = (state_r == S_LD_RD) ? cur_addr_r - AW'(MAX_WIDTH) : corner_addr;
  end

  always_comb begin
    ctrl           = '0;
    ctrl.pix_take  = in_fire && (in_ch.data.operation == OP_LOAD);
    ctrl.row_clr   = lx == '0;
    ctrl.rd_en     = (state_r == S_LD_RD) || (state_r == S_Q_RD);
    ctrl.wr_en     = state_r == S_LD_WR;
    ctrl.above_vld = !cur_y0_r;
    ctrl.acc_clr   = state_r == S_Q_MUL;
    ctrl.acc_en    = tag_vld_r;
    ctrl.acc_sub   = tag_sub_r;
    ctrl.acc_zero  = tag_zero_r;
    ctrl.div_start = state_r == S_Q_DS;
    ctrl.div_step  = state_r == S_Q_DIV;
  end

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    bbmf_lane #(.AW(AW), .PW(PW)) u_lane (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctrl   (ctrl),
      .pix    (pix[g]),
      .rd_addr(rd_addr),
      .wr_addr(cur_addr_r),
      .area   (area_r),
      .mean   (mean[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      radius_r  <= RADIUS_RST;
      width_r   <= WIDTH_RST;
      height_r  <= HEIGHT_RST;
      ld_x_r    <= '0;
      ld_y_r    <= '0;
      ld_addr_r <= '0;
      ld_rb_r   <= '0;
      cnt_r     <= '0;
      tag_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      tag_vld_r <= state_r == S_Q_RD;
      if (out_vld_r && out_ch.ready && state_r != S_Q_OUT) out_vld_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            if (in_ch.data.operation == OP_LOAD) begin
              cur_addr_r <= laddr;
              cur_y0_r   <= ly == '0;
              if (lx + XW'(1) >= w_eff) begin
                ld_x_r <= '0;
                if (ly + XW'(1) >= h_eff) begin
                  ld_y_r    <= '0;
                  ld_addr_r <= '0;
                  ld_rb_r   <= '0;
                end else begin
                  ld_y_r    <= ly + XW'(1);
                  ld_addr_r <= lrb + AW'(MAX_WIDTH);
                  ld_rb_r   <= lrb + AW'(MAX_WIDTH);
                end
              end else begin
                ld_x_r    <= lx + XW'(1);
                ld_y_r    <= ly;
                ld_addr_r <= laddr + AW'(1);
                ld_rb_r   <= lrb;
              end
              state_r <= S_LD_RD;
            end else begin
              qx_r <= (XW'(in_ch.data.query_x) > w_eff - XW'(1)) ? w_eff - XW'(1)
                                                                 : XW'(in_ch.data.query_x);
              qy_r <= (XW'(in_ch.data.query_y) > h_eff - XW'(1)) ? h_eff - XW'(1)
                                                                 : XW'(in_ch.data.query_y);
              state_r <= S_Q_BND;
            end
          end
        end
        S_LD_RD: state_r <= S_LD_WR;
        S_LD_WR: state_r <= S_IDLE;
        S_Q_BND: begin
          x1_r    <= x1;
          x2_r    <= x2;
          y1_r    <= y1;
          y2_r    <= y2;
          state_r <= S_Q_MUL;
        end
        S_Q_MUL: begin
          area_r  <= PW'(x2_r - x1_r) * PW'(y2_r - y1_r);
          yb2_r   <= AW'((y2_r - XW'(1)) * MAX_WIDTH);
          yb1_r   <= AW'((y1_r - XW'(1)) * MAX_WIDTH);
          x1z_r   <= x1_r == '0;
          y1z_r   <= y1_r == '0;
          cnt_r   <= '0;
          state_r <= S_Q_RD;
        end
        S_Q_RD: begin
          tag_sub_r  <= (cnt_r[1:0] == 2'd1) || (cnt_r[1:0] == 2'd2);
          tag_zero_r <= corner_zero;
          cnt_r      <= cnt_r + 5'd1;
          if (cnt_r[1:0] == 2'd3) state_r <= S_Q_LAST;
        end
        S_Q_LAST: state_r <= S_Q_DS;
        S_Q_DS: begin
          cnt_r   <= '0;
          state_r <= S_Q_DIV;
        end
        S_Q_DIV: begin
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'd31) state_r <= S_Q_OUT;
        end
        S_Q_OUT: begin
          // merge the lane means into the result register
          if (!out_vld_r || out_ch.ready) begin
            out_r.out_red   <= mean[0];
            out_r.out_green <= mean[1];
            out_r.out_blue  <= mean[2];
            out_r.out_alpha <= mean[3];
            out_vld_r       <= 1'b1;
            state_r         <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
      if (cfg_fire) begin
        case (cfg_ch.data.index)
          CFG_RADIUS: radius_r <= cfg_ch.data.data[5:0];
          CFG_WIDTH: begin
            width_r   <= cfg_ch.data.data;
            ld_x_r    <= '0;
            ld_y_r    <= '0;
            ld_addr_r <= '0;
            ld_rb_r   <= '0;
          end
          CFG_HEIGHT: begin
            height_r  <= cfg_ch.data.data;
            ld_x_r    <= '0;
            ld_y_r    <= '0;
            ld_addr_r <= '0;
            ld_rb_r   <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  a_load_writes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_ch.data.operation == OP_LOAD) |=> ##1 ctrl.wr_en)
    else $error("load did not write its table word");

  a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (ld_x_r < XW'(MAX_WIDTH)) && (ld_y_r < XW'(MAX_HEIGHT)))
    else $error("load position out of table range");

  a_area_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_Q_DIV) |-> (area_r != '0))
    else $error("divide by zero window");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> $past(state_r == S_Q_OUT))
    else $error("result word raised outside the output state");
endmodule
